@@ sv/mrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrd_pkg: shared types and constants for the modem response detector
// Pattern length limit, status codes, register indexes and the pattern
// matcher step.
// ----------------------------------------------------------------------------
package mrd_pkg;

  localparam int unsigned MaxPatternLen = 8;
  localparam int unsigned CharW         = 8;
  localparam int unsigned PatternW      = MaxPatternLen * CharW;
  localparam int unsigned LenW          = $clog2(MaxPatternLen + 1);
  localparam int unsigned PosW          = $clog2(MaxPatternLen);
  localparam int unsigned TickW         = 16;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = PatternW;

  localparam logic [CharW-1:0] LineFeed = 8'h0a;

  // Latched result; the encoding doubles as the reported status.
  typedef enum logic [StatusW-1:0] {
    KIND_ACK     = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  localparam logic [CfgIdxW-1:0] CFG_ACK_PATTERN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_LENGTH    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_PATTERN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_LENGTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 3'd4;

  localparam logic [PatternW-1:0] AckPatternRst   = 64'd19279;
  localparam logic [LenW-1:0]     AckLengthRst    = 4'd2;
  localparam logic [PatternW-1:0] ErrorPatternRst = 64'd353174213189;
  localparam logic [LenW-1:0]     ErrorLengthRst  = 4'd5;
  localparam logic [TickW-1:0]    TimeoutRst      = 16'd1000;

  typedef struct packed {
    logic [LenW-1:0] count;
    logic            hit;
  } match_t;

  // One matcher step: compare the byte with the next expected character.
  function automatic match_t match_step(input logic [PatternW-1:0] pat,
                                        input logic [LenW-1:0]     len,
                                        input logic [LenW-1:0]     count,
                                        input logic [CharW-1:0]    ch);
    logic [LenW-1:0] lim;
    logic [PosW-1:0] pos;
    logic [CharW-1:0] exp_ch;
    match_t res;
    lim = (len > LenW'(MaxPatternLen)) ? LenW'(MaxPatternLen) : len;
    pos = (count >= lim) ? '0 : count[PosW-1:0];
    exp_ch = pat[pos*CharW +: CharW];
    if (lim == '0) begin
      res.count = '0;
      res.hit   = 1'b1;
    end else begin
      if (exp_ch == ch) begin
        res.count = LenW'(pos) + LenW'(1);
      end else begin
        res.count = (pat[CharW-1:0] == ch) ? LenW'(1) : '0;
      end
      res.hit = (res.count == lim);
    end
    return res;
  endfunction

endpackage

@@ sv/modem_response_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_detector_core: acknowledge / error response detector
// Matches received characters against two programmable patterns and reports
// the outcome at a line feed or after an idle timeout.
// ----------------------------------------------------------------------------
// One beat per cycle unless a new report meets a full output that is not taken.
// A beat is registered at the input, then the two pattern compares and the idle
// counter update run combinationally and any status lands in the output register.
// The output register frees the input side: beats that give no report keep
// flowing while a status waits; a second report stalls the input until the first
// is taken. Input tuser[0] = 1 marks a 1 ms tick, 0 a received character in tdata.
// Registers are to be written only while idle; the block does not enforce it.
module modem_response_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mrd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]                    s_axis_tuser,   // [0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata    // [1:0] status, [7:2] zero
);
  import mrd_pkg::*;

  // configuration
  logic [PatternW-1:0] ack_pat_q, err_pat_q;
  logic [LenW-1:0]     ack_len_q, err_len_q;
  logic [TickW-1:0]    timeout_q;

  // matcher state
  logic [LenW-1:0]  ack_cnt_q, ack_cnt_d;
  logic [LenW-1:0]  err_cnt_q, err_cnt_d;
  kind_e            found_q, found_d;
  logic [TickW-1:0] idle_q, idle_d;

  // input register
  logic             in_valid_q;
  logic             in_tick_q;
  logic [CharW-1:0] in_char_q;

  // output register
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;

  match_t           ack_m, err_m;
  kind_e            found_new;
  logic [TickW-1:0] idle_inc;
  logic             res_valid;
  kind_e            res_kind;
  logic             adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_pat_q <= AckPatternRst;
      ack_len_q <= AckLengthRst;
      err_pat_q <= ErrorPatternRst;
      err_len_q <= ErrorLengthRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACK_PATTERN:   ack_pat_q <= cfg_wdata_i;
        CFG_ACK_LENGTH:    ack_len_q <= cfg_wdata_i[LenW-1:0];
        CFG_ERROR_PATTERN: err_pat_q <= cfg_wdata_i;
        CFG_ERROR_LENGTH:  err_len_q <= cfg_wdata_i[LenW-1:0];
        CFG_TIMEOUT_TICKS: timeout_q <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ack_m     = match_step(ack_pat_q, ack_len_q, ack_cnt_q, in_char_q);
    err_m     = match_step(err_pat_q, err_len_q, err_cnt_q, in_char_q);
    idle_inc  = idle_q + TickW'(1);
    ack_cnt_d = ack_cnt_q;
    err_cnt_d = err_cnt_q;
    found_d   = found_q;
    idle_d    = idle_q;
    found_new = found_q;
    res_valid = 1'b0;
    res_kind  = found_q;
    if (!in_tick_q) begin
      idle_d = '0;
      if (found_q == KIND_NONE) begin
        ack_cnt_d = ack_m.count;
        if (ack_m.hit) begin
          found_new = KIND_ACK;
        end else begin
          // error matcher is left alone on the byte that completes ack
          err_cnt_d = err_m.count;
          if (err_m.hit) begin
            found_new = KIND_ERROR;
          end
        end
      end
      found_d  = found_new;
      res_kind = found_new;
      res_valid = (in_char_q == LineFeed) && (found_new != KIND_NONE);
    end else begin
      idle_d = idle_inc;
      res_valid = (idle_inc >= timeout_q) || (timeout_q == '0);
      res_kind  = (found_q == KIND_NONE) ? KIND_TIMEOUT : found_q;
    end
    if (res_valid) begin
      ack_cnt_d = '0;
      err_cnt_d = '0;
      found_d   = KIND_NONE;
      idle_d    = '0;
    end
  end

  // stage moves on unless it holds a report and the output is still full
  assign adv           = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ack_cnt_q   <= '0;
      err_cnt_q   <= '0;
      found_q     <= KIND_NONE;
      idle_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        ack_cnt_q <= ack_cnt_d;
        err_cnt_q <= err_cnt_d;
        found_q   <= found_d;
        idle_q    <= idle_d;
      end
      if (adv && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick_q <= s_axis_tuser[0];
      in_char_q <= s_axis_tdata;
    end
    if (adv && res_valid) begin
      out_status_q <= res_kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - StatusW){1'b0}}, out_status_q};

  // a reported beat never carries the "none found" code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[StatusW-1:0] != KIND_NONE))
    else $error("report carries none-found code");

  // every report wipes the matcher state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_valid) |=> (found_q == KIND_NONE && ack_cnt_q == '0 &&
                            err_cnt_q == '0 && idle_q == '0))
    else $error("state not cleared after report");

  // input only stalls behind a pending report that is not being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready && res_valid))
    else $error("unexpected input stall");

  // a held stage item is still there next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q)
    else $error("stage item dropped");

  // match counts never run past the pattern limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack_cnt_q <= LenW'(MaxPatternLen)) && (err_cnt_q <= LenW'(MaxPatternLen)))
    else $error("match count out of range");

endmodule

@@ sim/tb_modem_response_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modem_response_detector_core: self-checking bench for the response detector
// A directed script at the programmed defaults, extremes and odd lengths, then
// random phases of acknowledge / error text, noise, line feeds and tick runs.
// A bit-accurate matcher predicts each status beat. Both stream sides idle at
// random, and registers are reprogrammed between phases once all status is in.
// ----------------------------------------------------------------------------
module tb_modem_response_detector_core;
  import mrd_pkg::*;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_e;

  typedef struct packed {
    row_e                kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
    logic                op;
    logic [CharW-1:0]    ch;
    logic                typed;
    kind_e               want;
  } script_row_t;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] char_code
  logic [0:0]          s_axis_tuser  = '0;   // [0] opcode
  logic                m_axis_tready = 1'b0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire  [7:0]          m_axis_tdata;         // [1:0] status, [7:2] zero

  modem_response_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the programmed registers and of the matcher state
  logic [PatternW-1:0] ack_pat  = AckPatternRst;
  logic [LenW-1:0]     ack_len  = AckLengthRst;
  logic [PatternW-1:0] err_pat  = ErrorPatternRst;
  logic [LenW-1:0]     err_len  = ErrorLengthRst;
  logic [TickW-1:0]    tmo      = TimeoutRst;
  logic [LenW-1:0]     ack_cnt  = '0;
  logic [LenW-1:0]     err_cnt  = '0;
  kind_e               found    = KIND_NONE;
  logic [TickW-1:0]    idle_ticks = '0;

  kind_e       status_fifo[$];
  script_row_t script_q[$];
  kind_e       popped_status;
  int          mismatches  = 0;
  int          beats_taken = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void clear_response();
    ack_cnt    = '0;
    err_cnt    = '0;
    found      = KIND_NONE;
    idle_ticks = '0;
  endfunction

  // One matcher step; returns 1 when the pattern completes on this byte.
  function automatic bit advance_matcher(input logic [PatternW-1:0] pat,
                                         input logic [LenW-1:0] len,
                                         inout logic [LenW-1:0] cnt,
                                         input logic [CharW-1:0] ch);
    logic [LenW-1:0] lim;
    logic [LenW-1:0] pos;
    lim = (len > LenW'(MaxPatternLen)) ? LenW'(MaxPatternLen) : len;
    if (lim == '0) begin
      cnt = '0;
      return 1'b1;
    end
    pos = (cnt >= lim) ? '0 : cnt;
    if (pat[CharW*pos +: CharW] == ch) begin
      pos = pos + LenW'(1);
    end else begin
      // restart: the byte may open a new match
      pos = (pat[CharW-1:0] == ch) ? LenW'(1) : '0;
    end
    cnt = pos;
    return pos == lim;
  endfunction

  function automatic bit predict_response(input logic op, input logic [CharW-1:0] ch,
                                          output kind_e status);
    status = KIND_NONE;
    if (op == OP_CHAR) begin
      idle_ticks = '0;
      if (found == KIND_NONE) begin
        if (advance_matcher(ack_pat, ack_len, ack_cnt, ch)) begin
          found = KIND_ACK;
        end else if (advance_matcher(err_pat, err_len, err_cnt, ch)) begin
          found = KIND_ERROR;
        end
      end
      if (ch == LineFeed && found != KIND_NONE) begin
        status = found;
        clear_response();
        return 1'b1;
      end
      return 1'b0;
    end
    idle_ticks = idle_ticks + TickW'(1);
    if (idle_ticks >= tmo || tmo == '0) begin
      status = (found == KIND_NONE) ? KIND_TIMEOUT : found;
      clear_response();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drive one beat; a typed row overrides the predicted status.
  task automatic send_beat(input logic op, input logic [CharW-1:0] ch,
                           input logic typed, input kind_e want);
    kind_e predicted;
    bit    has_status;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_taken++;
    has_status = predict_response(op, ch, predicted);
    if (typed) begin
      if (want != KIND_NONE) status_fifo.push_back(want);
    end else if (has_status) begin
      status_fifo.push_back(predicted);
    end
  endtask

  // Hold off the input until every status is in and the pipe is empty.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_ACK_PATTERN:   ack_pat = value;
      CFG_ACK_LENGTH:    ack_len = value[LenW-1:0];
      CFG_ERROR_PATTERN: err_pat = value;
      CFG_ERROR_LENGTH:  err_len = value[LenW-1:0];
      CFG_TIMEOUT_TICKS: tmo     = value[TickW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_beat(input logic op, input logic [CharW-1:0] ch,
                          input logic typed, input kind_e want);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_BEAT;
    row.op    = op;
    row.ch    = ch;
    row.typed = typed;
    row.want  = want;
    script_q.push_back(row);
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    row.want  = KIND_NONE;
    script_q.push_back(row);
  endtask

  // Small alphabet so that patterns and noise overlap often.
  function automatic logic [CharW-1:0] noise_char();
    if ($urandom_range(15) == 0) return LineFeed;
    if ($urandom_range(1) == 0) return CharW'("A" + $urandom_range(3));
    return CharW'($urandom_range(255));
  endfunction

  function automatic logic [CfgDataW-1:0] random_pattern();
    logic [CfgDataW-1:0] pat;
    for (int i = 0; i < MaxPatternLen; i++) pat[CharW*i +: CharW] = noise_char();
    return pat;
  endfunction

  function automatic logic [CfgDataW-1:0] random_length();
    logic [CfgDataW-1:0] value;
    value = {$urandom, $urandom};
    value[LenW-1:0] = ($urandom_range(7) == 0) ? LenW'($urandom_range(15))
                                               : LenW'($urandom_range(1, 4));
    return value;
  endfunction

  function automatic logic [CfgDataW-1:0] random_timeout();
    logic [CfgDataW-1:0] value;
    value = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       value[TickW-1:0] = TickW'($urandom_range(65535));
      1:       value[TickW-1:0] = '0;
      default: value[TickW-1:0] = TickW'($urandom_range(1, 12));
    endcase
    return value;
  endfunction

  task automatic program_phase(input int phase);
    wait_for_results();
    case (phase)
      3: begin
        write_reg(CFG_ACK_PATTERN, '1);
        write_reg(CFG_ACK_LENGTH, CfgDataW'(8));
        write_reg(CFG_ERROR_PATTERN, '0);
        write_reg(CFG_ERROR_LENGTH, CfgDataW'(8));
        write_reg(CFG_TIMEOUT_TICKS, '0);
      end
      6: begin
        write_reg(CFG_ACK_PATTERN, random_pattern());
        write_reg(CFG_ACK_LENGTH, '0);
        write_reg(CFG_ERROR_PATTERN, random_pattern());
        write_reg(CFG_ERROR_LENGTH, CfgDataW'(15));
        write_reg(CFG_TIMEOUT_TICKS, CfgDataW'(16'hffff));
      end
      default: begin
        // lengths change while counts may be mid-match
        write_reg(CFG_ACK_PATTERN, random_pattern());
        write_reg(CFG_ACK_LENGTH, random_length());
        write_reg(CFG_ERROR_PATTERN, random_pattern());
        write_reg(CFG_ERROR_LENGTH, random_length());
        write_reg(CFG_TIMEOUT_TICKS, random_timeout());
      end
    endcase
    // unmapped index must leave everything alone
    write_reg(CfgIdxW'($urandom_range(5, 7)), {$urandom, $urandom});
  endtask

  // Pattern text with an occasional corrupted byte or stray tick.
  task automatic send_text(input logic [PatternW-1:0] pat, input logic [LenW-1:0] len);
    int              lim;
    logic [CharW-1:0] ch;
    lim = (len > LenW'(MaxPatternLen)) ? MaxPatternLen : int'(len);
    for (int i = 0; i < lim; i++) begin
      if ($urandom_range(5) == 0) send_beat(OP_TICK, CharW'($urandom_range(255)), 1'b0, KIND_NONE);
      ch = pat[CharW*i +: CharW];
      if ($urandom_range(7) == 0) ch = noise_char();
      send_beat(OP_CHAR, ch, 1'b0, KIND_NONE);
    end
    if ($urandom_range(3) != 0) send_beat(OP_CHAR, LineFeed, 1'b0, KIND_NONE);
  endtask

  task automatic run_random(input int target);
    int n;
    while (beats_taken < target) begin
      case ($urandom_range(19))
        0: begin
          if ($urandom_range(2) == 0) wait_for_results();
          send_beat(OP_TICK, CharW'($urandom_range(255)), 1'b0, KIND_NONE);
        end
        1, 2, 3, 4, 5, 6, 7: send_text(ack_pat, ack_len);
        8, 9, 10, 11:        send_text(err_pat, err_len);
        12, 13: begin
          n = $urandom_range(1, 5);
          repeat (n) send_beat(OP_CHAR, noise_char(), 1'b0, KIND_NONE);
        end
        14, 15: send_beat(OP_CHAR, LineFeed, 1'b0, KIND_NONE);
        16, 17: begin
          n = (tmo <= 40) ? $urandom_range(int'(tmo) + 1) : $urandom_range(8);
          repeat (n) send_beat(OP_TICK, CharW'($urandom_range(255)), 1'b0, KIND_NONE);
        end
        default: send_beat(OP_TICK, CharW'($urandom_range(255)), 1'b0, KIND_NONE);
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_fifo.size() == 0) begin
        report_mismatch($sformatf("status beat 0x%02h with none expected", m_axis_tdata));
      end else begin
        popped_status = status_fifo.pop_front();
        if (m_axis_tdata[1:0] !== popped_status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_axis_tdata[1:0], popped_status));
        end
        if (m_axis_tdata[7:2] !== '0) begin
          report_mismatch($sformatf("status pad bits 0x%02h not zero", m_axis_tdata));
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    script_row_t row;
    int          target;

    // defaults: ack "OK", error text bytes 45 d2 d2 3a 52, 1000 ticks
    add_beat(OP_CHAR, LineFeed, 1'b1, KIND_NONE);
    add_beat(OP_CHAR, "O", 1'b0, KIND_NONE);
    add_beat(OP_CHAR, "K", 1'b0, KIND_NONE);
    add_beat(OP_CHAR, LineFeed, 1'b1, KIND_ACK);
    add_beat(OP_CHAR, 8'h45, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, 8'hd2, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, 8'hd2, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, 8'h3a, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, 8'h52, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, LineFeed, 1'b1, KIND_ERROR);
    // zero timeout: first tick ends the response
    add_write(CFG_TIMEOUT_TICKS, '0);
    add_beat(OP_TICK, 8'hff, 1'b1, KIND_TIMEOUT);
    // zero-length ack latches on any byte, reported by the next tick
    add_write(CFG_ACK_LENGTH, '0);
    add_beat(OP_CHAR, 8'h00, 1'b1, KIND_NONE);
    add_beat(OP_TICK, 8'h00, 1'b1, KIND_ACK);
    // ack length above the limit, zero-length error wins on a line feed
    add_write(CFG_ACK_PATTERN, '1);
    add_write(CFG_ACK_LENGTH, 64'hffff_ffff_ffff_ffff);
    add_write(CFG_ERROR_LENGTH, 64'hffff_ffff_ffff_fff0);
    add_beat(OP_CHAR, LineFeed, 1'b1, KIND_ERROR);
    // all-NUL error text, length 9 clamps to 8, longest timeout
    add_write(CFG_ERROR_PATTERN, '0);
    add_write(CFG_ERROR_LENGTH, 64'hffff_ffff_ffff_fff9);
    add_write(CFG_TIMEOUT_TICKS, 64'hffff_ffff_ffff_ffff);
    add_write(3'd7, 64'h0);
    repeat (8) add_beat(OP_CHAR, 8'h00, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, LineFeed, 1'b0, KIND_NONE);
    add_beat(OP_TICK, 8'h00, 1'b0, KIND_NONE);
    add_beat(OP_CHAR, 8'hff, 1'b0, KIND_NONE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 8;
    rx_idle_pct = 82;
    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.kind == ROW_WRITE) begin
        wait_for_results();
        write_reg(row.idx, row.value);
      end else begin
        send_beat(row.op, row.ch, row.typed, row.want);
      end
    end

    target = beats_taken;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 3) begin
        tx_idle_pct = 82;
        rx_idle_pct = 8;
      end else if (phase == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      program_phase(phase);
      target += 85;
      run_random(target);
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
